@@ rtl/frc_pkg.sv @@
`timescale 1ns / 1ps
package frc_pkg;
  localparam int unsigned TGT_W = 26;
  localparam int unsigned DAMP_W = 17;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned ZOOM_W = 24;
  localparam int unsigned DIM_W = 16;
  localparam int unsigned DVD_W = 64;
  localparam int unsigned DVS_W = 48;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned FAC_W = 30;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_DAMPING = 1'b1;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic [TGT_W-1:0] TGT_RESET = 26'd655360;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd32768;
  localparam logic [DAMP_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [ZOOM_W-1:0] ZOOM_ONE = 24'd65536;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX = 24'hFFFFFF;
  localparam logic [DVD_W-1:0] RATE_NUM = 64'd65536000;
  localparam logic [DVD_W-1:0] MIN_NUM = 64'd8388608;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage

@@ rtl/frc_div.sv @@
`timescale 1ns / 1ps
module frc_div
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [6:0] cnt;
  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;

  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rem <= diff[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/frc_sqrt.sv @@
`timescale 1ns / 1ps
module frc_sqrt
  import frc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  radicand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  logic [DVD_W-1:0] val;
  logic [ROOT_W+2:0] rem;
  logic [5:0] cnt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;

  assign rem_sh = {rem[ROOT_W:0], val[DVD_W-1:DVD_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      val <= {val[DVD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= diff;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/frame_rate_resolution_controller.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// s_axis    in   s_tvalid/s_tready       s_tdata, s_tuser, s_tlast
// m_axis    out  m_tvalid/m_tready       m_tdata
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Records with no frame close need no arithmetic; a frame close with a positive
// frame time runs the serial divider.
// An update request runs four serial divisions, a bit-serial square root and two
// registered multiplies. Hold requests skip the arithmetic. Synchronous reset
// restores the FSM, configuration, rate and timestamp registers and m_tvalid.
// A pending result waits in the output register; records keep flowing.
module frame_rate_resolution_controller
  import frc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // end_time[47:0], zoom_in[71:48], parent_width[87:72],
  // parent_height[103:88], channel_width[119:104], channel_height[135:120]
  input  logic [135:0] s_tdata,
  // req_type[0], stat_kind[3:1], hold[4]
  input  logic [4:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // zoom_out[23:0]
  output logic [23:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [25:0]  cfg_data
);
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RDIV_GO = 5'd1;
  localparam logic [4:0] ST_RDIV_W  = 5'd2;
  localparam logic [4:0] ST_QDIV_GO = 5'd3;
  localparam logic [4:0] ST_QDIV_W  = 5'd4;
  localparam logic [4:0] ST_SQ_GO   = 5'd5;
  localparam logic [4:0] ST_SQ_W    = 5'd6;
  localparam logic [4:0] ST_MUL1    = 5'd7;
  localparam logic [4:0] ST_MUL2    = 5'd8;
  localparam logic [4:0] ST_MUL3    = 5'd9;
  localparam logic [4:0] ST_LO_GO   = 5'd10;
  localparam logic [4:0] ST_LO_W    = 5'd11;
  localparam logic [4:0] ST_HX_GO   = 5'd12;
  localparam logic [4:0] ST_HX_W    = 5'd13;
  localparam logic [4:0] ST_HY_GO   = 5'd14;
  localparam logic [4:0] ST_HY_W    = 5'd15;
  localparam logic [4:0] ST_FIN     = 5'd16;

  logic [4:0] state, state_next;
  logic [TGT_W-1:0] target_rate;
  logic [DAMP_W-1:0] damping;
  logic [RATE_W-1:0] measured_rate;
  logic [TIME_W-1:0] previous_end;
  logic [TIME_W-1:0] batch_latest_end;
  logic [TIME_W-1:0] frame_time;

  logic [ZOOM_W-1:0] zin;
  logic [DIM_W-1:0] pw, ph, cw, ch;
  logic hold_r;
  logic [DVD_W-1:0] qv;
  logic [ROOT_W-1:0] sroot;
  logic signed [50:0] prod1;
  logic [FAC_W-1:0] factor;
  logic [53:0] prod2;
  logic [ZOOM_W-1:0] lo;
  logic [32:0] hx, hy;

  unit_ctl_t dv, sq;
  logic [DVD_W-1:0] dv_dividend, dv_quot;
  logic [DVS_W-1:0] dv_divisor;
  logic [ROOT_W-1:0] sq_root;

  logic accept, is_update, kind_ok;
  logic [TIME_W-1:0] t_in, end_v;
  logic [TIME_W:0] time_diff;
  logic [TGT_W-1:0] tgt_eff;
  logic [DAMP_W-1:0] damp_eff;
  logic [DIM_W-1:0] pmin;
  logic signed [32:0] delta;
  logic signed [50:0] corr;
  logic [32:0] hi_raw;
  logic [ZOOM_W-1:0] hi;
  logic [37:0] zoom_v, zoom_lo;
  logic [ZOOM_W-1:0] zoom_fin;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign is_update = (s_tuser[0] == REQ_UPDATE);
  assign kind_ok = (s_tuser[3:1] <= 3'd3);
  assign t_in = s_tdata[47:0];
  assign end_v = (kind_ok && t_in > batch_latest_end) ? t_in : batch_latest_end;
  assign time_diff = {1'b0, end_v} - {1'b0, previous_end};
  assign out_free = !m_tvalid || m_tready;

  assign tgt_eff = (target_rate == '0) ? TGT_W'(1) : target_rate;
  assign damp_eff = (damping > ONE_Q16) ? ONE_Q16 : damping;
  assign pmin = (pw < ph) ? pw : ph;
  assign delta = $signed({1'b0, sroot}) - 33'sd65536;
  assign corr = prod1 + (prod1[50] ? 51'sd65535 : 51'sd0);
  assign hi_raw = (hx < hy) ? hx : hy;
  assign hi = (hi_raw > {9'd0, ZOOM_MAX}) ? ZOOM_MAX : hi_raw[ZOOM_W-1:0];
  assign zoom_v = prod2[53:16];
  assign zoom_lo = (zoom_v < {14'd0, lo}) ? {14'd0, lo} : zoom_v;
  assign zoom_fin = hold_r ? ZOOM_ONE :
                    ((zoom_lo > {14'd0, hi}) ? hi : zoom_lo[ZOOM_W-1:0]);

  assign dv.start = (state == ST_RDIV_GO) || (state == ST_QDIV_GO) ||
                    (state == ST_LO_GO) || (state == ST_HX_GO) || (state == ST_HY_GO);
  assign sq.start = (state == ST_SQ_GO);

  always_comb begin
    dv_dividend = '0;
    dv_divisor = '0;
    unique case (state)
      ST_RDIV_GO: begin
        dv_dividend = RATE_NUM + DVD_W'(frame_time[TIME_W-1:1]);
        dv_divisor = frame_time;
      end
      ST_QDIV_GO: begin
        dv_dividend = {measured_rate, 32'd0};
        dv_divisor = DVS_W'(tgt_eff);
      end
      ST_LO_GO: begin
        dv_dividend = MIN_NUM;
        dv_divisor = DVS_W'(pmin);
      end
      ST_HX_GO: begin
        dv_dividend = DVD_W'({cw, 16'd0});
        dv_divisor = DVS_W'(pw);
      end
      ST_HY_GO: begin
        dv_dividend = DVD_W'({ch, 16'd0});
        dv_divisor = DVS_W'(ph);
      end
      default: ;
    endcase
  end

  frc_div u_div (
    .clk(clk), .rst(rst), .start(dv.start), .dividend(dv_dividend),
    .divisor(dv_divisor), .busy(dv.busy), .done(dv.done), .quotient(dv_quot)
  );

  frc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq.start), .radicand(qv),
    .busy(sq.busy), .done(sq.done), .root(sq_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_update) begin
            state_next = s_tuser[4] ? ST_FIN : ST_QDIV_GO;
          end else if (s_tlast && end_v != '0 && !time_diff[TIME_W] &&
                       time_diff[TIME_W-1:0] != '0) begin
            state_next = ST_RDIV_GO;
          end
        end
      end
      ST_RDIV_GO: state_next = ST_RDIV_W;
      ST_RDIV_W:  if (dv.done) state_next = ST_IDLE;
      ST_QDIV_GO: state_next = ST_QDIV_W;
      ST_QDIV_W:  if (dv.done) state_next = ST_SQ_GO;
      ST_SQ_GO:   state_next = ST_SQ_W;
      ST_SQ_W:    if (sq.done) state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_MUL3;
      ST_MUL3:    state_next = ST_LO_GO;
      ST_LO_GO:   state_next = ST_LO_W;
      ST_LO_W:    if (dv.done) state_next = ST_HX_GO;
      ST_HX_GO:   state_next = ST_HX_W;
      ST_HX_W:    if (dv.done) state_next = ST_HY_GO;
      ST_HY_GO:   state_next = ST_HY_W;
      ST_HY_W:    if (dv.done) state_next = ST_FIN;
      ST_FIN:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      target_rate <= TGT_RESET;
      damping <= DAMP_RESET;
      measured_rate <= RATE_W'(TGT_RESET);
      previous_end <= '0;
      batch_latest_end <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == REG_TARGET) begin
          target_rate <= cfg_data;
        end else begin
          damping <= cfg_data[DAMP_W-1:0];
        end
      end
      if (state == ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (accept && !is_update) begin
        if (s_tlast) begin
          batch_latest_end <= '0;
          if (end_v != '0) previous_end <= end_v;
        end else begin
          batch_latest_end <= end_v;
        end
      end
      if (state == ST_RDIV_W && dv.done) measured_rate <= dv_quot[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_time <= time_diff[TIME_W-1:0];
      zin <= s_tdata[71:48];
      pw <= (s_tdata[87:72] == '0) ? DIM_W'(1) : s_tdata[87:72];
      ph <= (s_tdata[103:88] == '0) ? DIM_W'(1) : s_tdata[103:88];
      cw <= s_tdata[119:104];
      ch <= s_tdata[135:120];
      hold_r <= s_tuser[4];
    end
    if (state == ST_QDIV_W && dv.done) qv <= dv_quot;
    if (state == ST_SQ_W && sq.done) sroot <= sq_root;
    if (state == ST_MUL1) prod1 <= 51'(delta * $signed({1'b0, damp_eff}));
    if (state == ST_MUL2) factor <= FAC_W'(32'sd65536 + 32'(corr >>> 16));
    if (state == ST_MUL3) prod2 <= 54'(zin) * 54'(factor);
    if (state == ST_LO_W && dv.done) lo <= dv_quot[ZOOM_W-1:0];
    if (state == ST_HX_W && dv.done) hx <= dv_quot[32:0];
    if (state == ST_HY_W && dv.done) hy <= dv_quot[32:0];
    if (state == ST_FIN && out_free) m_tdata <= zoom_fin;
  end

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !dv.busy && !sq.busy)
    else $error("input taken while an arithmetic unit runs");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dv.done |-> $past(dv.busy))
    else $error("divider done without a running division");
  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sq.done |-> (state == ST_SQ_W))
    else $error("square root finished outside its wait state");
  a_fin_units: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !dv.busy && !sq.busy)
    else $error("result formed while a unit still runs");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import frc_pkg::*;

  typedef struct packed {
    logic              req;
    logic [2:0]        kind;
    logic [TIME_W-1:0] end_t;
    logic              last;
    logic [ZOOM_W-1:0] zin;
    logic [DIM_W-1:0]  pw;
    logic [DIM_W-1:0]  ph;
    logic [DIM_W-1:0]  cw;
    logic [DIM_W-1:0]  ch;
    logic              hold;
  } frc_req_t;

  class zoom_scoreboard;
    logic [TGT_W-1:0]  target;
    logic [DAMP_W-1:0] damp;
    logic [63:0]       rate;
    logic [TIME_W-1:0] prev_end;
    logic [TIME_W-1:0] batch_end;
    logic [ZOOM_W-1:0] zoom_q[$];
    int                errors;

    function new();
      target = TGT_RESET;
      damp = DAMP_RESET;
      rate = 64'd655360;
      prev_end = '0;
      batch_end = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [25:0] val);
      if (idx == REG_TARGET) target = val[TGT_W-1:0];
      else damp = val[DAMP_W-1:0];
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [ZOOM_W-1:0] predict_zoom(frc_req_t it);
      logic [63:0] tgt, dmp, s, factor, zoom, pw, ph, pmin, lo, hx, hy, hi;
      longint      delta, corr;
      tgt = (target == 0) ? 64'd1 : 64'(target);
      dmp = (damp > ONE_Q16) ? 64'd65536 : 64'(damp);
      s = isqrt((rate << 32) / tgt);
      delta = longint'(s) - 65536;
      corr = (delta * longint'(dmp)) / 65536;
      factor = 64'(65536 + corr);
      zoom = (64'(it.zin) * factor) >> 16;
      pw = (it.pw == 0) ? 64'd1 : 64'(it.pw);
      ph = (it.ph == 0) ? 64'd1 : 64'(it.ph);
      pmin = (pw < ph) ? pw : ph;
      lo = (64'd128 << 16) / pmin;
      hx = (64'(it.cw) << 16) / pw;
      hy = (64'(it.ch) << 16) / ph;
      hi = (hx < hy) ? hx : hy;
      if (hi > 64'(ZOOM_MAX)) hi = 64'(ZOOM_MAX);
      if (zoom < lo) zoom = lo;
      if (zoom > hi) zoom = hi;
      return zoom[ZOOM_W-1:0];
    endfunction

    function void note_request(frc_req_t it);
      logic [TIME_W-1:0] e;
      longint            dt;
      if (it.req == REQ_UPDATE) begin
        zoom_q.push_back(it.hold ? ZOOM_ONE : predict_zoom(it));
        return;
      end
      if (it.kind <= 3 && it.end_t > batch_end) batch_end = it.end_t;
      if (it.last) begin
        e = batch_end;
        batch_end = '0;
        if (e != 0) begin
          dt = longint'(e) - longint'(prev_end);
          prev_end = e;
          if (dt > 0) rate = (64'd65536000 + 64'(dt) / 2) / 64'(dt);
        end
      end
    endfunction

    function void check_zoom(logic [ZOOM_W-1:0] got);
      logic [ZOOM_W-1:0] exp_z;
      if (zoom_q.size() == 0) begin
        $error("zoom_out: unexpected result %0d", got);
        errors++;
        return;
      end
      exp_z = zoom_q.pop_front();
      if (got !== exp_z) begin
        $error("zoom_out: expected %0d, actual %0d", exp_z, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [135:0]        s_tdata;
  logic [4:0]          s_tuser;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [25:0]         cfg_data;

  zoom_scoreboard sb = new();
  bit             no_idle;
  logic [47:0]    clock_ms;
  int unsigned    cycles;

  frame_rate_resolution_controller u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAIL frame_rate_resolution_controller");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) < 65);
    if (!rst && m_tvalid && m_tready) sb.check_zoom(m_tdata);
  end

  task automatic send_req(frc_req_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {it.ch, it.cw, it.ph, it.pw, it.zin, it.end_t};
    s_tuser <= {it.hold, it.kind, it.req};
    s_tlast <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.zoom_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [25:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function frc_req_t rec(logic [2:0] k, logic [47:0] t, logic l);
    frc_req_t it;
    it = '0;
    it.req = REQ_RECORD;
    it.kind = k;
    it.end_t = t;
    it.last = l;
    it.zin = 24'($urandom());
    it.pw = 16'($urandom());
    it.ph = 16'($urandom());
    it.cw = 16'($urandom());
    it.ch = 16'($urandom());
    it.hold = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function frc_req_t upd(logic [23:0] z, logic [15:0] pw, logic [15:0] ph,
                         logic [15:0] cw, logic [15:0] ch, logic h);
    frc_req_t it;
    it = '0;
    it.req = REQ_UPDATE;
    it.kind = 3'($urandom());
    it.end_t = 48'({$urandom(), $urandom()});
    it.last = 1'($urandom_range(0, 1));
    it.zin = z;
    it.pw = pw;
    it.ph = ph;
    it.cw = cw;
    it.ch = ch;
    it.hold = h;
    return it;
  endfunction

  function frc_req_t rand_upd();
    logic [15:0] pw, ph;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      pw = 16'($urandom_range(16, 2048));
      ph = 16'($urandom_range(16, 2048));
      return upd(24'($urandom_range(0, 24'h3FFFF)), pw, ph,
                 16'($urandom_range(0, 4 * pw)), 16'($urandom_range(0, 4 * ph)),
                 $urandom_range(0, 19) == 0);
    end
    return upd(24'($urandom()), (r < 95) ? 16'($urandom()) : 16'd0, 16'($urandom()),
               16'($urandom()), 16'($urandom()), $urandom_range(0, 9) == 0);
  endfunction

  task automatic run_random(int n);
    int          left, bsz, stride, k;
    logic [47:0] t;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 9) < 8) begin
        bsz = $urandom_range(1, 5);
        stride = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 250) : $urandom_range(0, 5000);
        if ($urandom_range(0, 29) == 0) clock_ms = clock_ms - 48'($urandom_range(0, 500));
        if ($urandom_range(0, 49) == 0) clock_ms = 48'({$urandom(), $urandom()});
        for (k = 0; k < bsz; k++) begin
          t = clock_ms + 48'($urandom_range(0, stride));
          send_req(rec(($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                     : 3'($urandom_range(0, 3)),
                       t, k == bsz - 1));
        end
        clock_ms = clock_ms + 48'(stride);
        left -= bsz;
      end else begin
        send_req(rec(3'($urandom()), 48'({$urandom(), $urandom()}),
                     1'($urandom_range(0, 1))));
        left--;
      end
      k = $urandom_range(0, 2);
      repeat (k) begin
        send_req(rand_upd());
        left--;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_TARGET;
    cfg_data = '0;
    cycles = 0;
    no_idle = 1'b0;
    clock_ms = 48'd1000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_req(upd(24'h010000, 16'd640, 16'd480, 16'd640, 16'd480, 1'b0));
    send_req(upd(24'hFFFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0));
    send_req(upd(24'h000000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_req(upd(24'h123456, 16'd0, 16'd0, 16'd5, 16'd7, 1'b0));
    send_req(upd(24'h020000, 16'd1000, 16'd1000, 16'd10, 16'd10, 1'b0));
    send_req(upd(24'h020000, 16'd100, 16'd100, 16'd0, 16'd0, 1'b1));
    send_req(rec(3'd4, 48'd50, 1'b1));
    send_req(rec(3'd0, 48'd100, 1'b0));
    send_req(rec(3'd1, 48'd120, 1'b0));
    send_req(rec(3'd2, 48'd110, 1'b0));
    send_req(rec(3'd7, 48'd900, 1'b0));
    send_req(rec(3'd3, 48'd125, 1'b1));
    send_req(rec(3'd5, 48'd140, 1'b1));
    send_req(rec(3'd0, 48'd141, 1'b1));
    send_req(upd(24'h010000, 16'd320, 16'd240, 16'd1280, 16'd960, 1'b0));
    send_req(rec(3'd1, 48'd90, 1'b1));
    send_req(rec(3'd2, 48'd90, 1'b1));
    send_req(upd(24'h010000, 16'd320, 16'd240, 16'd1280, 16'd960, 1'b0));
    send_req(rec(3'd3, 48'hFFFFFFFFFFFF, 1'b1));
    send_req(upd(24'h008000, 16'd320, 16'd240, 16'd1280, 16'd960, 1'b0));
    clock_ms = 48'd5000;

    write_reg(REG_TARGET, 26'd65536);
    write_reg(REG_DAMPING, 26'd65536);
    run_random(300);
    write_reg(REG_TARGET, 26'd65536000);
    write_reg(REG_DAMPING, 26'd0);
    run_random(250);
    drain();
    run_random(250);
    write_reg(REG_TARGET, 26'd0);
    write_reg(REG_DAMPING, 26'h1FFFF);
    run_random(200);
    write_reg(REG_TARGET, 26'h3FFFFFF);
    write_reg(REG_DAMPING, 26'd40000);
    run_random(200);
    write_reg(REG_TARGET, 26'($urandom_range(65536, 4000000)));
    write_reg(REG_DAMPING, 26'($urandom_range(0, 65536)));
    run_random(400);

    drain();
    if (sb.errors == 0) begin
      $display("PASS frame_rate_resolution_controller");
    end else begin
      $display("FAIL frame_rate_resolution_controller");
    end
    $finish;
  end
endmodule
